// ===== sv/art_pkg.sv =====
// shared constants, codes and controller/datapath interface structs
// for the arq retransmit table; no dependencies
package art_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int TIME_W = 32;
    localparam int PID_W  = 8;
    localparam int CNT_W  = 8;
    localparam int KIND_W = 3;

    // input modes
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // received header types
    localparam logic [1:0] RX_DATA = 2'd0;
    localparam logic [1:0] RX_ACK  = 2'd1;

    // result kinds
    localparam logic [KIND_W-1:0] K_TX      = 3'd0;
    localparam logic [KIND_W-1:0] K_ACK     = 3'd1;
    localparam logic [KIND_W-1:0] K_DELIVER = 3'd2;
    localparam logic [KIND_W-1:0] K_RESEND  = 3'd3;
    localparam logic [KIND_W-1:0] K_DROP    = 3'd4;
    localparam logic [KIND_W-1:0] K_ERROR   = 3'd5;
    localparam logic [KIND_W-1:0] K_STATUS  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MAXRES   = 2'd2;

    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd1000;
    localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd100;
    localparam logic [CNT_W-1:0]  MAXRES_RST   = 8'd3;

    typedef struct packed {
        logic              capture;    // latch the accepted input beat
        logic              send;       // take next id, store entry if possible
        logic              ack_rm;     // remove entry matching rx_pid
        logic              scan_start; // record scan time, clear expiry flags
        logic              eval;       // evaluate expiry of one entry
        logic              resend;     // restart picked entry
        logic              drop;       // remove picked entry
        logic              emit;       // load output register
        logic [KIND_W-1:0] kind;
        logic              last;
    } art_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] rx_type;
        logic       scan_due;
        logic       eval_end;
        logic       cand_any;
        logic       cand_over;
        logic       out_free;
    } art_sts_t;

endpackage

// ===== sv/arq_retransmit_table.sv =====
// top level of the arq retransmit table: controller plus datapath
// depends on art_pkg, art_ctrl and art_dp
//
//   channel  | signals                          | beat carries
//   ---------+----------------------------------+------------------------------------
//   s_axis   | tvalid tready tdata[39:0] tuser  | one request: send, rx header, tick
//   m_axis   | tvalid tready tdata[15:0] tuser  | one result, tlast on the final one
//            | tlast                            |
//   cfg      | cfg_valid cfg_ready cfg_index    | one config register write
//            | cfg_data                         |
//
// send request: tx result; data header: deliver, ack; ack header: entry removed, no
// result; unrecognized header: error result; tick: a scan if due, then status; a scan
// evaluates every entry, then resends, and a drop takes the place of the final empty
// pick; the expiry check walks the table one entry a cycle through a single
// subtract/compare unit. one request in flight; a new one is taken while its last
// result waits in the output register; stalled m_axis holds emitting states only
// reset clears valid bits, id counter and scan time and loads config defaults
module arq_retransmit_table
    import art_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // rx_pid[7:0], now[39:8]
    input  logic [3:0]          s_axis_tuser,   // mode[1:0], rx_type[3:2]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // pid[7:0], pending[8], overflow[9]
    output logic [KIND_W-1:0]   m_axis_tuser,   // kind[2:0]
    output logic                m_axis_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [TIME_W-1:0]   cfg_data
);

    art_cmd_t cmd;
    art_sts_t sts;

    assign cfg_ready = 1'b1;

    art_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    art_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/art_ctrl.sv =====
// controller state machine of the arq retransmit table
// depends on art_pkg; drives art_cmd_t to the datapath, reads art_sts_t
module art_ctrl
    import art_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  art_sts_t sts,
    output art_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_SEND = 4'd2;
    localparam logic [3:0] S_DLV  = 4'd3;
    localparam logic [3:0] S_ACK  = 4'd4;
    localparam logic [3:0] S_ERR  = 4'd5;
    localparam logic [3:0] S_EVAL = 4'd6;
    localparam logic [3:0] S_PICK = 4'd7;
    localparam logic [3:0] S_STAT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = K_STATUS;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.mode)
                    MODE_SEND: state_next = S_SEND;
                    MODE_RX:
                    begin
                        if (sts.rx_type == RX_DATA)
                            state_next = S_DLV;
                        else if (sts.rx_type == RX_ACK)
                        begin
                            cmd.ack_rm = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                            state_next = S_ERR;
                    end
                    MODE_TICK:
                    begin
                        if (sts.scan_due)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_EVAL;
                        end
                        else
                            state_next = S_STAT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.send   = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_TX;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DLV:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_DELIVER;
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_ACK;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_ERROR;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.eval_end)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                // expired entries go out lowest id first; a drop ends the scan
                if (!sts.cand_any)
                    state_next = S_STAT;
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.cand_over)
                    begin
                        cmd.drop   = 1'b1;
                        cmd.kind   = K_DROP;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        cmd.resend = 1'b1;
                        cmd.kind   = K_RESEND;
                    end
                end
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_STATUS;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/art_dp.sv =====
// datapath of the arq retransmit table: entry table, id counter, scan timer,
// config registers and output register; depends on art_pkg
module art_dp
    import art_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [39:0]         s_axis_tdata,   // rx_pid[7:0], now[39:8]
    input  logic [3:0]          s_axis_tuser,   // mode[1:0], rx_type[3:2]
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [TIME_W-1:0]   cfg_data,
    input  art_cmd_t            cmd,
    output art_sts_t            sts,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // pid[7:0], pending[8], overflow[9]
    output logic [KIND_W-1:0]   m_axis_tuser,   // kind[2:0]
    output logic                m_axis_tlast
);

    // config
    logic [TIME_W-1:0] timeout_reg, timeout_next;
    logic [TIME_W-1:0] interval_reg, interval_next;
    logic [CNT_W-1:0]  maxres_reg, maxres_next;

    // latched input beat
    logic [1:0]        mode_reg, mode_next;
    logic [1:0]        rxtype_reg, rxtype_next;
    logic [PID_W-1:0]  rxpid_reg, rxpid_next;
    logic [TIME_W-1:0] now_reg, now_next;

    // table
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [PID_W-1:0]       pid_reg  [TABLE_DEPTH];
    logic [PID_W-1:0]       pid_next [TABLE_DEPTH];
    logic [TIME_W-1:0]      sent_reg  [TABLE_DEPTH];
    logic [TIME_W-1:0]      sent_next [TABLE_DEPTH];
    logic [CNT_W-1:0]       rsnd_reg  [TABLE_DEPTH];
    logic [CNT_W-1:0]       rsnd_next [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] flag_reg, flag_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    logic [PID_W-1:0]  next_id_reg, next_id_next;
    logic [TIME_W-1:0] last_scan_reg, last_scan_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [PID_W-1:0]  out_pid_reg, out_pid_next;
    logic              out_pend_reg, out_pend_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_last_reg, out_last_next;

    // combinational helpers
    logic [PID_W-1:0]       id_inc;
    logic [TABLE_DEPTH-1:0] id_hit, ack_hit, free_vec, free_oh, sel;
    logic                   store_ok;
    logic [TIME_W-1:0]      age;
    logic                   expired;
    logic [PID_W-1:0]       pick_pid;
    logic [CNT_W-1:0]       pick_rsnd;
    logic [TIME_W-1:0]      since_scan;
    logic [PID_W-1:0]       emit_pid;

    assign id_inc = next_id_reg + PID_W'(1);

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            id_hit[i]  = valid_reg[i] && (pid_reg[i] == id_inc);
            ack_hit[i] = valid_reg[i] && (pid_reg[i] == rxpid_reg);
        end
    end

    // lowest free slot as one-hot
    assign free_vec = ~valid_reg;
    assign free_oh  = free_vec & (~free_vec + TABLE_DEPTH'(1));
    assign store_ok = !(|id_hit) && (|free_vec);

    assign age     = now_reg - sent_reg[idx_reg];
    assign expired = valid_reg[idx_reg] && (age > timeout_reg);

    // flagged entry with the smallest id; ids in the table are unique
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel[i] = flag_reg[i];
            for (int j = 0; j < TABLE_DEPTH; j++)
                if (j != i && flag_reg[j] && !(pid_reg[i] < pid_reg[j]))
                    sel[i] = 1'b0;
        end
    end

    always_comb
    begin
        pick_pid  = '0;
        pick_rsnd = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sel[i])
            begin
                pick_pid  = pick_pid | pid_reg[i];
                pick_rsnd = pick_rsnd | rsnd_reg[i];
            end
        end
    end

    assign since_scan = now_reg - last_scan_reg;

    assign sts.mode      = mode_reg;
    assign sts.rx_type   = rxtype_reg;
    assign sts.scan_due  = since_scan > interval_reg;
    assign sts.eval_end  = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.cand_any  = |flag_reg;
    assign sts.cand_over = pick_rsnd > maxres_reg;
    assign sts.out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        case (cmd.kind)
            K_TX:                  emit_pid = id_inc;
            K_RESEND, K_DROP:      emit_pid = pick_pid;
            K_ACK, K_DELIVER,
            K_ERROR:               emit_pid = rxpid_reg;
            default:               emit_pid = '0;
        endcase
    end

    always_comb
    begin
        timeout_next   = timeout_reg;
        interval_next  = interval_reg;
        maxres_next    = maxres_reg;
        mode_next      = mode_reg;
        rxtype_next    = rxtype_reg;
        rxpid_next     = rxpid_reg;
        now_next       = now_reg;
        valid_next     = valid_reg;
        pid_next       = pid_reg;
        sent_next      = sent_reg;
        rsnd_next      = rsnd_reg;
        flag_next      = flag_reg;
        idx_next       = idx_reg;
        next_id_next   = next_id_reg;
        last_scan_next = last_scan_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_pid_next   = out_pid_reg;
        out_pend_next  = out_pend_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  timeout_next  = cfg_data;
                CFG_INTERVAL: interval_next = cfg_data;
                CFG_MAXRES:   maxres_next   = cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end

        if (cmd.capture)
        begin
            mode_next   = s_axis_tuser[1:0];
            rxtype_next = s_axis_tuser[3:2];
            rxpid_next  = s_axis_tdata[7:0];
            now_next    = s_axis_tdata[39:8];
        end

        if (cmd.send)
        begin
            next_id_next = id_inc;
            if (store_ok)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (free_oh[i])
                    begin
                        valid_next[i] = 1'b1;
                        pid_next[i]   = id_inc;
                        sent_next[i]  = now_reg;
                        rsnd_next[i]  = '0;
                    end
                end
            end
        end

        if (cmd.ack_rm)
            valid_next = valid_reg & ~ack_hit;

        if (cmd.scan_start)
        begin
            last_scan_next = now_reg;
            flag_next      = '0;
            idx_next       = '0;
        end

        if (cmd.eval)
        begin
            flag_next[idx_reg] = expired;
            idx_next           = idx_reg + IDX_W'(1);
        end

        if (cmd.resend)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (sel[i])
                begin
                    if (rsnd_reg[i] != {CNT_W{1'b1}})
                        rsnd_next[i] = rsnd_reg[i] + CNT_W'(1);
                    sent_next[i] = now_reg;
                    flag_next[i] = 1'b0;
                end
            end
        end

        if (cmd.drop)
        begin
            valid_next = valid_reg & ~sel;
            flag_next  = flag_reg & ~sel;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.kind;
            out_pid_next   = emit_pid;
            out_pend_next  = (cmd.kind == K_STATUS) && (|valid_reg);
            out_ovf_next   = (cmd.kind == K_TX) && !store_ok;
            out_last_next  = cmd.last;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            interval_reg  <= INTERVAL_RST;
            maxres_reg    <= MAXRES_RST;
            valid_reg     <= '0;
            flag_reg      <= '0;
            idx_reg       <= '0;
            next_id_reg   <= '0;
            last_scan_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            interval_reg  <= interval_next;
            maxres_reg    <= maxres_next;
            valid_reg     <= valid_next;
            flag_reg      <= flag_next;
            idx_reg       <= idx_next;
            next_id_reg   <= next_id_next;
            last_scan_reg <= last_scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        rxtype_reg   <= rxtype_next;
        rxpid_reg    <= rxpid_next;
        now_reg      <= now_next;
        pid_reg      <= pid_next;
        sent_reg     <= sent_next;
        rsnd_reg     <= rsnd_next;
        out_kind_reg <= out_kind_next;
        out_pid_reg  <= out_pid_next;
        out_pend_reg <= out_pend_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_ovf_reg, out_pend_reg, out_pid_reg};

endmodule
